// File: hdl/rgbc_pkg.sv
// Shared constants and types for the RGB 7x7 convolution block.
package rgbc_pkg;

    // Kernel geometry
    localparam int KS       = 7;
    localparam int LINES    = KS - 1;
    localparam int TAPS     = KS * KS;
    localparam int HALF     = KS / 2;

    // Frame limits
    localparam int MAX_WIDTH  = 2048;
    localparam int ROW_LIMIT  = 4096;

    // Channels and sample widths
    localparam int NCH      = 3;
    localparam int SAMPW    = 8;
    localparam int PIXW     = NCH * SAMPW;
    localparam int COEFW    = 16;
    localparam int FRACW    = 16;
    localparam int PRODW    = COEFW + SAMPW;
    localparam int ROWW     = PRODW + $clog2(KS);
    localparam int TOTW     = ROWW + $clog2(KS);
    localparam int SHW      = TOTW - FRACW;

    // Field widths
    localparam int COLW     = $clog2(MAX_WIDTH);
    localparam int ROWCW    = 12;
    localparam int FWW      = 12;
    localparam int FHW      = 13;
    localparam int IDXW     = 6;
    localparam int SLOTW    = $clog2(LINES);
    localparam int CFG_IDXW = 1;
    localparam int CFG_DW   = 13;

    // Configuration register indexes
    localparam logic [CFG_IDXW-1:0] CFG_WIDTH  = CFG_IDXW'(0);
    localparam logic [CFG_IDXW-1:0] CFG_HEIGHT = CFG_IDXW'(1);

    // Request codes
    localparam logic REQ_COEF  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // Reset frame size
    localparam logic [FWW-1:0] FW_RESET = FWW'(1600);
    localparam logic [FHW-1:0] FH_RESET = FHW'(900);

    typedef logic [KS-1:0][KS-1:0][PIXW-1:0] t_window;
    typedef logic [TAPS-1:0][COEFW-1:0]      t_kernel;

    // Position and end-of-frame flag carried along with one item
    typedef struct packed {
        logic [ROWCW-1:0] row;
        logic [COLW-1:0]  col;
        logic             last;
    } t_meta;

endpackage

// File: hdl/rgbc_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
module rgbc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/rgbc_mac.sv
// Multiply-accumulate pipeline: products, row sums, total with saturation.
module rgbc_mac (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  rgbc_pkg::t_meta              i_meta,
    input  rgbc_pkg::t_window            i_win,
    input  rgbc_pkg::t_kernel            i_kernel,
    output logic                         o_valid,
    output rgbc_pkg::t_meta              o_meta,
    output logic [rgbc_pkg::SAMPW-1:0]   o_red,
    output logic [rgbc_pkg::SAMPW-1:0]   o_green,
    output logic [rgbc_pkg::SAMPW-1:0]   o_blue,
    output logic                         o_clipped
);

    logic [rgbc_pkg::NCH-1:0][rgbc_pkg::KS-1:0][rgbc_pkg::KS-1:0][rgbc_pkg::PRODW-1:0] r_prod;
    logic [rgbc_pkg::NCH-1:0][rgbc_pkg::KS-1:0][rgbc_pkg::ROWW-1:0] r_rsum;
    logic [rgbc_pkg::NCH-1:0][rgbc_pkg::KS-1:0][rgbc_pkg::ROWW-1:0] n_rsum;
    logic [rgbc_pkg::NCH-1:0][rgbc_pkg::SAMPW-1:0] r_res;
    logic [rgbc_pkg::NCH-1:0][rgbc_pkg::SAMPW-1:0] n_res;
    logic [rgbc_pkg::NCH-1:0] n_clip;
    logic [rgbc_pkg::TOTW-1:0] w_tot [rgbc_pkg::NCH];
    logic [rgbc_pkg::SHW-1:0]  w_sh  [rgbc_pkg::NCH];
    logic r_pv, r_sv, r_ov, r_clip;
    rgbc_pkg::t_meta r_pm, r_sm, r_om;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_sv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
            r_sv <= r_pv;
            r_ov <= r_sv;
        end
    end

    // Stage 1: one product per tap and channel
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pm <= i_meta;
            for (int ch = 0; ch < rgbc_pkg::NCH; ch++) begin
                for (int r = 0; r < rgbc_pkg::KS; r++) begin
                    for (int c = 0; c < rgbc_pkg::KS; c++) begin
                        r_prod[ch][r][c] <=
                            rgbc_pkg::PRODW'(i_kernel[r*rgbc_pkg::KS+c])
                            * rgbc_pkg::PRODW'(i_win[r][c][ch*rgbc_pkg::SAMPW +: rgbc_pkg::SAMPW]);
                    end
                end
            end
        end
    end

    // Stage 2: sum along each kernel row
    always_comb begin
        for (int ch = 0; ch < rgbc_pkg::NCH; ch++) begin
            for (int r = 0; r < rgbc_pkg::KS; r++) begin
                n_rsum[ch][r] = '0;
                for (int c = 0; c < rgbc_pkg::KS; c++) begin
                    n_rsum[ch][r] = n_rsum[ch][r] + rgbc_pkg::ROWW'(r_prod[ch][r][c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sm   <= r_pm;
            r_rsum <= n_rsum;
        end
    end

    // Stage 3: total, drop fraction, saturate
    always_comb begin
        for (int ch = 0; ch < rgbc_pkg::NCH; ch++) begin
            w_tot[ch] = '0;
            for (int r = 0; r < rgbc_pkg::KS; r++) begin
                w_tot[ch] = w_tot[ch] + rgbc_pkg::TOTW'(r_rsum[ch][r]);
            end
            w_sh[ch] = w_tot[ch][rgbc_pkg::TOTW-1:rgbc_pkg::FRACW];
            if (w_sh[ch] > rgbc_pkg::SHW'(255)) begin
                n_res[ch]  = '1;
                n_clip[ch] = 1'b1;
            end else begin
                n_res[ch]  = w_sh[ch][rgbc_pkg::SAMPW-1:0];
                n_clip[ch] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_om   <= r_sm;
            r_res  <= n_res;
            r_clip <= |n_clip;
        end
    end

    assign o_valid   = r_ov;
    assign o_meta    = r_om;
    assign o_red     = r_res[0];
    assign o_green   = r_res[1];
    assign o_blue    = r_res[2];
    assign o_clipped = r_clip;

endmodule

// File: hdl/rgb_2d_convolution_7x7_top.sv
// Top level of the streaming RGB 7x7 convolution block.
// Takes one item (pixel or coefficient) per clock. Six line RAMs (one per
// buffered row, indexed by column) are read and written at the incoming column
// in the accept cycle; the item then passes the stage 1 register, the 7x7
// window registers shift as it leaves stage 1, then three registered
// multiply/add stages follow, the last being the output register. The whole
// pipeline, line RAM reads included, holds while a result waits at the output
// under stall, so the rate is one item per clock whenever the consumer takes
// results. Coefficient loads travel in order with pixels and take effect for
// every later pixel.
module rgb_2d_convolution_7x7_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item input
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_req_type,
    input  logic [rgbc_pkg::IDXW-1:0]        i_coef_index,
    input  logic [rgbc_pkg::COEFW-1:0]       i_coef_value,
    input  logic [rgbc_pkg::SAMPW-1:0]       i_in_red,
    input  logic [rgbc_pkg::SAMPW-1:0]       i_in_green,
    input  logic [rgbc_pkg::SAMPW-1:0]       i_in_blue,
    // result output
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [rgbc_pkg::ROWCW-1:0]       o_out_row,
    output logic [rgbc_pkg::COLW-1:0]        o_out_col,
    output logic [rgbc_pkg::SAMPW-1:0]       o_out_red,
    output logic [rgbc_pkg::SAMPW-1:0]       o_out_green,
    output logic [rgbc_pkg::SAMPW-1:0]       o_out_blue,
    output logic                             o_clipped,
    output logic                             o_frame_done,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rgbc_pkg::CFG_IDXW-1:0]    i_cfg_index,
    input  logic [rgbc_pkg::CFG_DW-1:0]      i_cfg_data
);

    logic w_adv, w_acc;
    logic [rgbc_pkg::FWW-1:0]   r_fw, w_w;
    logic [rgbc_pkg::FHW-1:0]   r_fh, w_h;
    logic [rgbc_pkg::COLW-1:0]  r_col;
    logic [rgbc_pkg::ROWCW-1:0] r_row;
    logic [rgbc_pkg::SLOTW-1:0] r_ymod;
    logic w_col_end, w_row_end, w_emit;
    logic [rgbc_pkg::PIXW-1:0] w_pix;

    logic                        r_s1_valid, r_s1_pix, r_s1_emit;
    logic [rgbc_pkg::PIXW-1:0]   r_s1_data;
    logic [rgbc_pkg::IDXW-1:0]   r_s1_idx;
    logic [rgbc_pkg::COEFW-1:0]  r_s1_coef;
    logic [rgbc_pkg::SLOTW-1:0]  r_s1_ymod;
    rgbc_pkg::t_meta             r_s1_meta;

    logic                        r_s2_valid;
    rgbc_pkg::t_meta             r_s2_meta;

    logic [rgbc_pkg::PIXW-1:0]   w_rd   [rgbc_pkg::LINES];
    logic [rgbc_pkg::PIXW-1:0]   w_line [rgbc_pkg::LINES];
    logic [rgbc_pkg::SLOTW:0]    w_slot [rgbc_pkg::LINES];
    rgbc_pkg::t_window           r_win;
    rgbc_pkg::t_kernel           r_kernel;
    rgbc_pkg::t_meta             w_ometa;

    // Pipeline advances unless a result is held at the output
    assign w_adv       = !(o_valid && i_stall);
    assign o_stall     = !w_adv;
    assign w_acc       = i_valid && w_adv;
    assign o_cfg_ready = 1'b1;
    assign w_pix       = {i_in_blue, i_in_green, i_in_red};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= rgbc_pkg::FW_RESET;
            r_fh <= rgbc_pkg::FH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rgbc_pkg::CFG_WIDTH:  r_fw <= i_cfg_data[rgbc_pkg::FWW-1:0];
                rgbc_pkg::CFG_HEIGHT: r_fh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped frame size and raster position tests
    always_comb begin
        if (r_fw < rgbc_pkg::FWW'(rgbc_pkg::KS))             w_w = rgbc_pkg::FWW'(rgbc_pkg::KS);
        else if (r_fw > rgbc_pkg::FWW'(rgbc_pkg::MAX_WIDTH)) w_w = rgbc_pkg::FWW'(rgbc_pkg::MAX_WIDTH);
        else                                                  w_w = r_fw;
        if (r_fh < rgbc_pkg::FHW'(rgbc_pkg::KS))             w_h = rgbc_pkg::FHW'(rgbc_pkg::KS);
        else if (r_fh > rgbc_pkg::FHW'(rgbc_pkg::ROW_LIMIT)) w_h = rgbc_pkg::FHW'(rgbc_pkg::ROW_LIMIT);
        else                                                  w_h = r_fh;
        w_col_end = (rgbc_pkg::FWW'(r_col) + rgbc_pkg::FWW'(1)) >= w_w;
        w_row_end = (rgbc_pkg::FHW'(r_row) + rgbc_pkg::FHW'(1)) >= w_h;
        w_emit    = (r_row >= rgbc_pkg::ROWCW'(rgbc_pkg::LINES))
                 && (r_col >= rgbc_pkg::COLW'(rgbc_pkg::LINES));
    end

    // Raster counters; r_ymod tracks row mod line count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ymod <= '0;
        end else if (w_acc && i_req_type == rgbc_pkg::REQ_PIXEL) begin
            if (w_col_end) begin
                r_col <= '0;
                if (w_row_end) begin
                    r_row  <= '0;
                    r_ymod <= '0;
                end else begin
                    r_row  <= r_row + rgbc_pkg::ROWCW'(1);
                    r_ymod <= (r_ymod == rgbc_pkg::SLOTW'(rgbc_pkg::LINES - 1))
                            ? '0 : r_ymod + rgbc_pkg::SLOTW'(1);
                end
            end else begin
                r_col <= r_col + rgbc_pkg::COLW'(1);
            end
        end
    end

    // Stage 1 item register (line RAM read in flight)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_pix       <= i_req_type;
            r_s1_emit      <= w_emit;
            r_s1_data      <= w_pix;
            r_s1_idx       <= i_coef_index;
            r_s1_coef      <= i_coef_value;
            r_s1_ymod      <= r_ymod;
            r_s1_meta.row  <= r_row - rgbc_pkg::ROWCW'(rgbc_pkg::LINES - rgbc_pkg::HALF);
            r_s1_meta.col  <= r_col - rgbc_pkg::COLW'(rgbc_pkg::LINES - rgbc_pkg::HALF);
            r_s1_meta.last <= w_col_end && w_row_end;
        end
    end

    // Line RAMs, one per buffered row; read-first keeps the old row on overwrite
    for (genvar l = 0; l < rgbc_pkg::LINES; l++) begin : g_line
        rgbc_ram #(
            .WIDTH (rgbc_pkg::PIXW),
            .DEPTH (rgbc_pkg::MAX_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_acc && i_req_type == rgbc_pkg::REQ_PIXEL
                      && r_ymod == rgbc_pkg::SLOTW'(l)),
            .i_waddr (r_col),
            .i_wdata (w_pix),
            .i_re    (w_adv),
            .i_raddr (r_col),
            .o_rdata (w_rd[l])
        );
    end

    // Window row r takes line slot (row + r) mod line count
    always_comb begin
        for (int r = 0; r < rgbc_pkg::LINES; r++) begin
            w_slot[r] = (rgbc_pkg::SLOTW+1)'(r_s1_ymod) + (rgbc_pkg::SLOTW+1)'(r);
            if (w_slot[r] >= (rgbc_pkg::SLOTW+1)'(rgbc_pkg::LINES)) begin
                w_slot[r] = w_slot[r] - (rgbc_pkg::SLOTW+1)'(rgbc_pkg::LINES);
            end
            w_line[r] = w_rd[w_slot[r][rgbc_pkg::SLOTW-1:0]];
        end
    end

    // Window shift on each pixel
    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid && r_s1_pix == rgbc_pkg::REQ_PIXEL) begin
            for (int r = 0; r < rgbc_pkg::KS; r++) begin
                for (int c = 0; c < rgbc_pkg::KS - 1; c++) begin
                    r_win[r][c] <= r_win[r][c+1];
                end
            end
            for (int r = 0; r < rgbc_pkg::LINES; r++) begin
                r_win[r][rgbc_pkg::KS-1] <= w_line[r];
            end
            r_win[rgbc_pkg::KS-1][rgbc_pkg::KS-1] <= r_s1_data;
        end
    end

    // Kernel store, written in item order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= '0;
        end else if (w_adv && r_s1_valid && r_s1_pix == rgbc_pkg::REQ_COEF
                     && r_s1_idx < rgbc_pkg::IDXW'(rgbc_pkg::TAPS)) begin
            r_kernel[r_s1_idx] <= r_s1_coef;
        end
    end

    // Stage 2: window current, only interior pixels go on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid && r_s1_pix == rgbc_pkg::REQ_PIXEL && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_meta <= r_s1_meta;
        end
    end

    rgbc_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_valid   (r_s2_valid),
        .i_meta    (r_s2_meta),
        .i_win     (r_win),
        .i_kernel  (r_kernel),
        .o_valid   (o_valid),
        .o_meta    (w_ometa),
        .o_red     (o_out_red),
        .o_green   (o_out_green),
        .o_blue    (o_out_blue),
        .o_clipped (o_clipped)
    );

    assign o_out_row    = w_ometa.row;
    assign o_out_col    = w_ometa.col;
    assign o_frame_done = w_ometa.last;

endmodule

// File: hdl/rgbc_check.sv
// Port-level assertions for the convolution block, bound to the top level.
module rgbc_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [rgbc_pkg::ROWCW-1:0]    o_out_row,
    input logic [rgbc_pkg::COLW-1:0]     o_out_col
);

    // Reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A held result blocks the input side
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input accepted while result held");

    // A held result stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_row) && $stable(o_out_col)))
        else $error("held result changed");

    // Centre positions are always interior
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_row >= rgbc_pkg::ROWCW'(rgbc_pkg::HALF)
                     && o_out_col >= rgbc_pkg::COLW'(rgbc_pkg::HALF)
                     && o_out_col <= rgbc_pkg::COLW'(rgbc_pkg::MAX_WIDTH - 1 - rgbc_pkg::HALF)))
        else $error("result outside interior");

endmodule

bind rgb_2d_convolution_7x7_top rgbc_check u_rgbc_check (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_out_row (o_out_row),
    .o_out_col (o_out_col)
);

// File: verif/testbench.sv
// Self-checking testbench for the streaming RGB 7x7 convolution block.
`timescale 1ns / 100ps

module testbench;

    // One filtered pixel as it leaves the block
    typedef struct {
        logic [rgbc_pkg::ROWCW-1:0] row;
        logic [rgbc_pkg::COLW-1:0]  col;
        logic [7:0]                 red;
        logic [7:0]                 green;
        logic [7:0]                 blue;
        logic                       clip;
        logic                       done;
    } t_filtered_px;

    // Directed stimulus row; an item repeated reps times
    typedef struct {
        logic         req;
        logic [5:0]   idx;
        logic [15:0]  val;
        logic [7:0]   red;
        logic [7:0]   green;
        logic [7:0]   blue;
        int           reps;
        bit           has_exp;
        t_filtered_px exp_px;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic                          i_req_type = rgbc_pkg::REQ_COEF;
    logic [rgbc_pkg::IDXW-1:0]     i_coef_index = '0;
    logic [rgbc_pkg::COEFW-1:0]    i_coef_value = '0;
    logic [rgbc_pkg::SAMPW-1:0]    i_in_red = '0;
    logic [rgbc_pkg::SAMPW-1:0]    i_in_green = '0;
    logic [rgbc_pkg::SAMPW-1:0]    i_in_blue = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [rgbc_pkg::ROWCW-1:0]    o_out_row;
    logic [rgbc_pkg::COLW-1:0]     o_out_col;
    logic [rgbc_pkg::SAMPW-1:0]    o_out_red;
    logic [rgbc_pkg::SAMPW-1:0]    o_out_green;
    logic [rgbc_pkg::SAMPW-1:0]    o_out_blue;
    logic                          o_clipped;
    logic                          o_frame_done;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [rgbc_pkg::CFG_IDXW-1:0] i_cfg_index = rgbc_pkg::CFG_WIDTH;
    logic [rgbc_pkg::CFG_DW-1:0]   i_cfg_data = '0;

    rgb_2d_convolution_7x7_top i_dut (.*);

    always #1 i_clk = ~i_clk;

    // Predictor state
    bit [rgbc_pkg::COEFW-1:0] kern [rgbc_pkg::TAPS];
    bit [rgbc_pkg::PIXW-1:0]  line_mem [rgbc_pkg::LINES][rgbc_pkg::MAX_WIDTH];
    bit [rgbc_pkg::PIXW-1:0]  win [rgbc_pkg::KS][rgbc_pkg::KS];
    int unsigned    row_cnt = 0;
    int unsigned    col_cnt = 0;
    int unsigned    fw_reg = 1600;
    int unsigned    fh_reg = 900;

    t_filtered_px pending_px [$];
    int           fault_cnt = 0;
    int           send_idle = 0;
    int           rcv_idle = 0;

    // Advance the window by one pixel; returns 1 when a filtered pixel is due
    function automatic bit convolve_pixel(bit [rgbc_pkg::PIXW-1:0] pix,
                                          output t_filtered_px res);
        int unsigned w, h, x, y;
        longint unsigned acc;
        bit clip;
        bit emit, last;
        logic [7:0] chv [3];
        w = (fw_reg < rgbc_pkg::KS) ? rgbc_pkg::KS
          : (fw_reg > rgbc_pkg::MAX_WIDTH) ? rgbc_pkg::MAX_WIDTH : fw_reg;
        h = (fh_reg < rgbc_pkg::KS) ? rgbc_pkg::KS
          : (fh_reg > rgbc_pkg::ROW_LIMIT) ? rgbc_pkg::ROW_LIMIT : fh_reg;
        x = (col_cnt >= rgbc_pkg::MAX_WIDTH) ? rgbc_pkg::MAX_WIDTH - 1 : col_cnt;
        y = row_cnt;
        for (int r = 0; r < rgbc_pkg::KS; r++)
            for (int c = 0; c < rgbc_pkg::KS - 1; c++)
                win[r][c] = win[r][c+1];
        for (int r = 0; r < rgbc_pkg::LINES; r++)
            win[r][rgbc_pkg::KS-1] = line_mem[(y + r) % rgbc_pkg::LINES][x];
        win[rgbc_pkg::KS-1][rgbc_pkg::KS-1] = pix;
        line_mem[y % rgbc_pkg::LINES][x] = pix;
        emit = (y >= rgbc_pkg::KS - 1) && (x >= rgbc_pkg::KS - 1);
        last = (x + 1 >= w) && (y + 1 >= h);
        if (x + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            col_cnt = x + 1;
        end
        res = '{default: '0};
        if (!emit)
            return 1'b0;
        clip = 1'b0;
        for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (int r = 0; r < rgbc_pkg::KS; r++)
                for (int c = 0; c < rgbc_pkg::KS; c++)
                    acc += longint'(kern[r*rgbc_pkg::KS+c])
                         * ((win[r][c] >> (8*ch)) & 8'hFF);
            acc >>= rgbc_pkg::FRACW;
            if (acc > 255) begin
                acc = 255;
                clip = 1'b1;
            end
            chv[ch] = acc[7:0];
        end
        res.row   = rgbc_pkg::ROWCW'(y - (rgbc_pkg::KS - 1) + rgbc_pkg::HALF);
        res.col   = rgbc_pkg::COLW'(x - (rgbc_pkg::KS - 1) + rgbc_pkg::HALF);
        res.red   = chv[0];
        res.green = chv[1];
        res.blue  = chv[2];
        res.clip  = clip;
        res.done  = last;
        return 1'b1;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_cnt++;
        end
    endfunction

    function automatic void check_px(t_filtered_px want, t_filtered_px got);
        check_field("out_row", want.row, got.row);
        check_field("out_col", want.col, got.col);
        check_field("out_red", want.red, got.red);
        check_field("out_green", want.green, got.green);
        check_field("out_blue", want.blue, got.blue);
        check_field("clipped", want.clip, got.clip);
        check_field("frame_done", want.done, got.done);
    endfunction

    function automatic logic [7:0] rand_sample();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one item; the caller is at a falling edge and returns at one
    task automatic push_item(logic req, logic [5:0] idx, logic [15:0] val,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             output bit got, output t_filtered_px px);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_req_type   = req;
        i_coef_index = idx;
        i_coef_value = val;
        i_in_red     = r;
        i_in_green   = g;
        i_in_blue    = b;
        i_valid      = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        got = 1'b0;
        px = '{default: '0};
        if (req == rgbc_pkg::REQ_COEF) begin
            if (idx < rgbc_pkg::TAPS) kern[idx] = val;
        end else begin
            got = convolve_pixel({b, g, r}, px);
            if (got) pending_px.push_back(px);
        end
        @(negedge i_clk);
    endtask

    task automatic push_pixel();
        bit got;
        t_filtered_px px;
        push_item(rgbc_pkg::REQ_PIXEL, 6'($urandom_range(0, 63)),
                  16'($urandom_range(0, 65535)),
                  rand_sample(), rand_sample(), rand_sample(), got, px);
    endtask

    // Coefficient load; heavy weights saturate almost always
    task automatic push_coef(bit heavy);
        bit got;
        t_filtered_px px;
        int unsigned v;
        v = heavy ? $urandom_range(0, 65535) : $urandom_range(0, 2600);
        push_item(rgbc_pkg::REQ_COEF, 6'($urandom_range(0, 63)), 16'(v),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), got, px);
    endtask

    // Let every outstanding result out, then let the pipeline settle
    task automatic drain();
        i_valid = 1'b0;
        while (pending_px.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic set_reg(logic [rgbc_pkg::CFG_IDXW-1:0] idx,
                           logic [rgbc_pkg::CFG_DW-1:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == rgbc_pkg::CFG_WIDTH) fw_reg = data[rgbc_pkg::FWW-1:0];
        else fh_reg = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic finish_frame();
        while (row_cnt != 0 || col_cnt != 0) push_pixel();
    endtask

    // Random frames at one size, with kernel updates mixed in
    task automatic run_frames(logic [rgbc_pkg::CFG_DW-1:0] w,
                              logic [rgbc_pkg::CFG_DW-1:0] h, int frames);
        bit heavy;
        drain();
        set_reg(rgbc_pkg::CFG_WIDTH, w);
        set_reg(rgbc_pkg::CFG_HEIGHT, h);
        heavy = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < rgbc_pkg::TAPS; i++)
            if ($urandom_range(0, 1)) push_coef(heavy);
        for (int f = 0; f < frames; f++) begin
            push_pixel();
            while (row_cnt != 0 || col_cnt != 0) begin
                if ($urandom_range(0, 99) < 6) push_coef(heavy);
                push_pixel();
            end
        end
    endtask

    // Receiver stall
    always @(negedge i_clk)
        i_stall <= ($urandom_range(0, 99) < rcv_idle);

    // Result checker
    always @(posedge i_clk) begin
        t_filtered_px got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_row, o_out_col, o_out_red, o_out_green, o_out_blue,
                    o_clipped, o_frame_done};
            if (pending_px.size() == 0) begin
                $error("unexpected result at row %0d col %0d", o_out_row, o_out_col);
                fault_cnt++;
            end else begin
                check_px(pending_px.pop_front(), got);
            end
        end
    end

    // Directed table, run on a 7x7 frame so each pixel block yields one result
    t_stim_row dir_tab [12] = '{
        '{rgbc_pkg::REQ_PIXEL, 6'd0,  16'd0,    8'd255, 8'd255, 8'd255, 49, 1'b1,
          '{12'd3, 11'd3, 8'd0,   8'd0,   8'd0,   1'b0, 1'b1}},
        '{rgbc_pkg::REQ_COEF,  6'd0,  16'hFFFF, 8'd255, 8'd255, 8'd255, 1,  1'b0,
          '{default: '0}},
        '{rgbc_pkg::REQ_COEF,  6'd48, 16'hFFFF, 8'd0,   8'd0,   8'd0,   1,  1'b0,
          '{default: '0}},
        '{rgbc_pkg::REQ_COEF,  6'd49, 16'hFFFF, 8'd0,   8'd0,   8'd0,   1,  1'b0,
          '{default: '0}},
        '{rgbc_pkg::REQ_COEF,  6'd63, 16'hFFFF, 8'd0,   8'd0,   8'd0,   1,  1'b0,
          '{default: '0}},
        '{rgbc_pkg::REQ_PIXEL, 6'd0,  16'd0,    8'd255, 8'd255, 8'd255, 49, 1'b1,
          '{12'd3, 11'd3, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1}},
        '{rgbc_pkg::REQ_COEF,  6'd0,  16'd0,    8'd0,   8'd0,   8'd0,   1,  1'b0,
          '{default: '0}},
        '{rgbc_pkg::REQ_COEF,  6'd48, 16'd0,    8'd0,   8'd0,   8'd0,   1,  1'b0,
          '{default: '0}},
        '{rgbc_pkg::REQ_COEF,  6'd24, 16'h8000, 8'd0,   8'd0,   8'd0,   1,  1'b0,
          '{default: '0}},
        '{rgbc_pkg::REQ_PIXEL, 6'd63, 16'hFFFF, 8'd255, 8'd128, 8'd1,   49, 1'b1,
          '{12'd3, 11'd3, 8'd127, 8'd64,  8'd0,   1'b0, 1'b1}},
        '{rgbc_pkg::REQ_PIXEL, 6'd24, 16'h1234, 8'd0,   8'd0,   8'd0,   49, 1'b1,
          '{12'd3, 11'd3, 8'd0,   8'd0,   8'd0,   1'b0, 1'b1}},
        '{rgbc_pkg::REQ_PIXEL, 6'd0,  16'd0,    8'd255, 8'd255, 8'd255, 49, 1'b1,
          '{12'd3, 11'd3, 8'd127, 8'd127, 8'd127, 1'b0, 1'b1}}
    };

    initial begin
        bit got;
        t_filtered_px px;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Part of a row at reset size, then at the clamped widest row, then shrink
        send_idle = 37;
        rcv_idle  = 81;
        for (int i = 0; i < rgbc_pkg::TAPS; i++) push_coef(1'b0);
        repeat (20) push_pixel();
        drain();
        set_reg(rgbc_pkg::CFG_WIDTH, 13'h1FFF);
        repeat (20) push_pixel();
        drain();
        set_reg(rgbc_pkg::CFG_WIDTH, 13'd7);
        set_reg(rgbc_pkg::CFG_HEIGHT, 13'd7);
        finish_frame();

        // Directed part on a cleared kernel
        for (int i = 0; i < rgbc_pkg::TAPS; i++)
            push_item(rgbc_pkg::REQ_COEF, 6'(i), 16'd0, 8'd0, 8'd0, 8'd0, got, px);
        foreach (dir_tab[k]) begin
            for (int n = 0; n < dir_tab[k].reps; n++)
                push_item(dir_tab[k].req, dir_tab[k].idx, dir_tab[k].val,
                          dir_tab[k].red, dir_tab[k].green, dir_tab[k].blue, got, px);
            if (dir_tab[k].has_exp) begin
                check_field("directed result present", 1, got);
                check_px(dir_tab[k].exp_px, px);
            end
        end

        // Random frames under the three idling patterns
        for (int p = 0; p < 6; p++) begin
            send_idle = (p < 2) ? 37 : (p < 4) ? 81 : 0;
            rcv_idle  = (p < 2) ? 81 : (p < 4) ? 37 : 0;
            run_frames(rgbc_pkg::CFG_DW'($urandom_range(7, 10)),
                       rgbc_pkg::CFG_DW'($urandom_range(7, 9)), 1);
        end

        // Clamped smallest frame
        run_frames(13'd0, 13'd0, 1);

        // Tallest frame, cut short by lowering the height mid-frame
        drain();
        set_reg(rgbc_pkg::CFG_WIDTH, 13'd7);
        set_reg(rgbc_pkg::CFG_HEIGHT, 13'h1FFF);
        repeat (7 * 10) push_pixel();
        drain();
        set_reg(rgbc_pkg::CFG_HEIGHT, 13'd7);
        finish_frame();
        run_frames(13'd9, 13'd4096, 0);
        run_frames(13'd7, 13'd7, 1);

        drain();
        if (fault_cnt == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
